// ----- rtl/i2a_pkg.sv -----
// Shared types and constants of the integer to ASCII formatter.
`default_nettype none

package i2a_pkg;

  // Format modes carried in the cmd field
  typedef enum logic [1:0] {
    CMD_SDEC = 2'd0,
    CMD_UDEC = 2'd1,
    CMD_HEXL = 2'd2,
    CMD_HEXU = 2'd3
  } cmd_e;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned QueueDepth = 2;

  // One input transfer
  typedef struct packed {
    logic [1:0]            cmd;
    logic [ValueWidth-1:0] value;
  } in_t;

  // One result transfer
  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_t;

  // Classified work held between front and back
  typedef struct packed {
    logic                  hex;
    logic                  upper;
    logic                  neg;
    logic [ValueWidth-1:0] mag;
  } work_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- rtl/integer_to_ascii_formatter.sv -----
// Top level of the integer to ASCII formatter.
// A command (cmd, value) is taken when start_i is high and busy_o is low; up to
// two commands wait in a queue while the converter works, and busy_o rises
// when it is full. Each command yields 1 to 20 characters, most significant
// first, each shown on result_o for one cycle with valid_o high and the final
// one flagged by last; the receiver cannot stall, so it must take every
// strobe. A decimal command passes through a dequeue step, 64 double-dabble shift
// steps over a 20-digit BCD register, a minus sign if negative, then 20 digit
// slots with leading zeros skipped. A hex command passes through dequeue, the
// two prefix characters and the same 20 slots.
`default_nettype none

module integer_to_ascii_formatter import i2a_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire in_t  item_i,
  output logic      busy_o,
  output logic      valid_o,
  output out_t      result_o
);

  logic    push;
  logic    pop;
  work_t   entry;
  work_t   head;
  q_stat_t stat;

  // Classify incoming commands
  i2a_front u_front (
    .start_i (start_i),
    .item_i  (item_i),
    .stat_i  (stat),
    .busy_o  (busy_o),
    .push_o  (push),
    .entry_o (entry)
  );

  // Buffer work between the two sides
  i2a_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (stat)
  );

  // Convert and emit characters
  i2a_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .stat_i   (stat),
    .pop_o    (pop),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

// ----- rtl/i2a_front.sv -----
// Front end: accepts commands and classifies them into work entries.
`default_nettype none

module i2a_front import i2a_pkg::*; (
  input  wire logic    start_i,
  input  wire in_t     item_i,
  input  wire q_stat_t stat_i,
  output logic         busy_o,
  output logic         push_o,
  output work_t        entry_o
);

  // Hold off new commands while the queue is full
  assign busy_o = stat_i.full;
  assign push_o = start_i & ~stat_i.full;

  // Decode the mode and take the magnitude of a negative signed value
  always_comb begin
    entry_o.hex   = 1'b0;
    entry_o.upper = 1'b0;
    entry_o.neg   = 1'b0;
    case (cmd_e'(item_i.cmd))
      CMD_SDEC: entry_o.neg = item_i.value[ValueWidth-1];
      CMD_UDEC: entry_o.neg = 1'b0;
      CMD_HEXL: entry_o.hex = 1'b1;
      CMD_HEXU: begin
        entry_o.hex   = 1'b1;
        entry_o.upper = 1'b1;
      end
      default: entry_o.neg = 1'b0;
    endcase
    // The most negative value wraps to its own unsigned magnitude
    entry_o.mag = entry_o.neg ? (~item_i.value + ValueWidth'(1)) : item_i.value;
  end

endmodule

`default_nettype wire

// ----- rtl/i2a_queue.sv -----
// Short work queue between the front end and the converter.
`default_nettype none

module i2a_queue import i2a_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire work_t entry_i,
  input  wire logic  pop_i,
  output work_t      head_o,
  output q_stat_t    stat_o
);

  localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

  work_t               mem_q [QueueDepth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == CntWidth'(QueueDepth));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntWidth'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the entry on a push
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Never exceed the queue depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntWidth'(QueueDepth))
    else $error("queue occupancy above depth");

endmodule

`default_nettype wire

// ----- rtl/i2a_back.sv -----
// Back end: converts one work entry to digits and emits its characters.
`default_nettype none

module i2a_back import i2a_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire work_t   head_i,
  input  wire q_stat_t stat_i,
  output logic         pop_o,
  output logic         valid_o,
  output out_t         result_o
);

  localparam int unsigned NumDigits = 20;
  localparam int unsigned DigWidth  = 4 * NumDigits;
  localparam int unsigned LeftWidth = $clog2(NumDigits + 1);
  localparam int unsigned BitWidth  = $clog2(ValueWidth);

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharLow   = 8'h61;
  localparam logic [7:0] CharUp    = 8'h41;
  localparam logic [7:0] CharX     = 8'h78;
  localparam logic [7:0] CharMinus = 8'h2d;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PFX0,
    ST_PFX1,
    ST_DIG
  } state_e;

  state_e                state_q, state_d;
  logic                  hex_q, hex_d;
  logic                  upper_q, upper_d;
  logic                  neg_q, neg_d;
  logic                  started_q, started_d;
  logic [ValueWidth-1:0] mag_q, mag_d;
  logic [DigWidth-1:0]   dig_q, dig_d;
  logic [BitWidth-1:0]   bit_cnt_q, bit_cnt_d;
  logic [LeftWidth-1:0]  left_q, left_d;
  logic                  valid_q, valid_d;
  out_t                  result_q, result_d;
  logic [DigWidth-1:0]   adj;
  logic [3:0]            top;
  logic                  emit;

  // Map one digit to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
    logic [7:0] base;
    base = up ? CharUp : CharLow;
    if (d < 4'd10) begin
      digit_char = CharZero + {4'b0000, d};
    end else begin
      digit_char = base + {4'b0000, d} - 8'd10;
    end
  endfunction

  // Add three to every BCD digit of five or more before each shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ? dig_q[4*i +: 4] + 4'd3 : dig_q[4*i +: 4];
    end
  end

  assign top  = dig_q[DigWidth-1 -: 4];
  assign emit = started_q | (top != 4'd0) | (left_q == LeftWidth'(1));

  // Sequence load, conversion, prefix and digit emission
  always_comb begin
    state_d   = state_q;
    hex_d     = hex_q;
    upper_d   = upper_q;
    neg_d     = neg_q;
    started_d = started_q;
    mag_d     = mag_q;
    dig_d     = dig_q;
    bit_cnt_d = bit_cnt_q;
    left_d    = left_q;
    valid_d   = 1'b0;
    result_d  = result_q;
    pop_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!stat_i.empty) begin
          pop_o     = 1'b1;
          hex_d     = head_i.hex;
          upper_d   = head_i.upper;
          neg_d     = head_i.neg;
          started_d = 1'b0;
          left_d    = LeftWidth'(NumDigits);
          bit_cnt_d = '0;
          if (head_i.hex) begin
            dig_d   = {{(DigWidth-ValueWidth){1'b0}}, head_i.mag};
            state_d = ST_PFX0;
          end else begin
            dig_d   = '0;
            mag_d   = head_i.mag;
            state_d = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        dig_d     = {adj[DigWidth-2:0], mag_q[ValueWidth-1]};
        mag_d     = {mag_q[ValueWidth-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + BitWidth'(1);
        if (bit_cnt_q == BitWidth'(ValueWidth - 1)) begin
          state_d = neg_q ? ST_PFX0 : ST_DIG;
        end
      end
      ST_PFX0: begin
        valid_d       = 1'b1;
        result_d.last = 1'b0;
        if (hex_q) begin
          result_d.out_char = CharZero;
          state_d           = ST_PFX1;
        end else begin
          result_d.out_char = CharMinus;
          state_d           = ST_DIG;
        end
      end
      ST_PFX1: begin
        valid_d           = 1'b1;
        result_d.last     = 1'b0;
        result_d.out_char = CharX;
        state_d           = ST_DIG;
      end
      ST_DIG: begin
        // Drop leading zeros, keep the final digit always
        if (emit) begin
          valid_d           = 1'b1;
          result_d.out_char = digit_char(top, upper_q);
          result_d.last     = (left_q == LeftWidth'(1));
        end
        started_d = emit;
        dig_d     = {dig_q[DigWidth-5:0], 4'b0000};
        left_d    = left_q - LeftWidth'(1);
        if (left_q == LeftWidth'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and the registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bit_cnt_q <= '0;
      left_q    <= '0;
      started_q <= 1'b0;
      valid_q   <= 1'b0;
      result_q  <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      left_q    <= left_d;
      started_q <= started_d;
      valid_q   <= valid_d;
      result_q  <= result_d;
    end
  end

  // Hold work payload
  always_ff @(posedge clk_i) begin
    hex_q    <= hex_d;
    upper_q  <= upper_d;
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    dig_q    <= dig_d;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !stat_i.empty)
    else $error("pop from empty queue");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CONV) |-> (bit_cnt_q == '0))
    else $error("conversion counter not cleared");

  a_dig_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIG) |-> (left_q != '0))
    else $error("digit slot count ran out");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && result_q.last) |-> (state_q == ST_IDLE))
    else $error("final character while work remains");

endmodule

`default_nettype wire

// ----- tb/sv/integer_to_ascii_formatter_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the integer to ASCII formatter: table-driven and random numbers.
module integer_to_ascii_formatter_tb;
  import i2a_pkg::*;

  localparam int unsigned RandomItems = 256;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned ResetCycles = 11;

  localparam logic [63:0] AllOnes = '1;
  localparam logic [63:0] MinNeg  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxPos  = 64'h7fff_ffff_ffff_ffff;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharX     = 8'h78;
  localparam logic [7:0] CharMinus = 8'h2d;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  in_t  item_i  = '0;
  logic busy_o;
  logic valid_o;
  out_t result_o;

  // Typed-in characters for the item on item_i; empty means use the formatter model
  string held_text = "";

  // Characters still owed by the block, oldest first
  out_t pending_chars[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Directed stimulus table
  cmd_e        row_cmd[$];
  logic [63:0] row_value[$];
  string       row_text[$];

  always #5 clk_i = ~clk_i;

  integer_to_ascii_formatter u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .busy_o   (busy_o),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic void push_char(input logic [7:0] c, input logic is_last);
    pending_chars.push_back(out_t'{out_char: c, last: is_last});
  endfunction

  // Build the expected character string of one number
  function automatic void format_number(input in_t it);
    cmd_e        mode;
    logic [63:0] mag;
    logic [3:0]  nib;
    logic [7:0]  digits[$];
    logic [7:0]  chars[$];
    mode = cmd_e'(it.cmd);
    mag  = it.value;
    if (mode == CMD_SDEC && mag[63]) begin
      chars.push_back(CharMinus);
      mag = ~mag + 64'd1;
    end
    if (mode == CMD_SDEC || mode == CMD_UDEC) begin
      do begin
        digits.push_front(CharZero + 8'(mag % 64'd10));
        mag = mag / 64'd10;
      end while (mag != 64'd0);
    end else begin
      chars.push_back(CharZero);
      chars.push_back(CharX);
      do begin
        nib = mag[3:0];
        if (nib < 4'd10) begin
          digits.push_front(CharZero + {4'd0, nib});
        end else begin
          digits.push_front(((mode == CMD_HEXU) ? CharUpA : CharLowA) + {4'd0, nib} - 8'd10);
        end
        mag = mag >> 4;
      end while (mag != 64'd0);
    end
    foreach (digits[k]) chars.push_back(digits[k]);
    foreach (chars[k]) push_char(chars[k], k == chars.size() - 1);
  endfunction

  // Check each strobed character, then record the expectation of a new transfer
  always @(posedge clk_i) begin : check_chars
    out_t        want;
    int unsigned k;
    if (rst_ni) begin
      if (valid_o === 1'b1) begin
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last %b",
                                    result_o.out_char, result_o.last));
        end else begin
          want = pending_chars.pop_front();
          if (result_o.out_char !== want.out_char) begin
            report_mismatch($sformatf("out_char 0x%02h, want 0x%02h",
                                      result_o.out_char, want.out_char));
          end
          if (result_o.last !== want.last) begin
            report_mismatch($sformatf("last %b, want %b on char 0x%02h",
                                      result_o.last, want.last, want.out_char));
          end
        end
      end
      if (start_i && busy_o === 1'b0) begin
        if (held_text.len() == 0) begin
          format_number(item_i);
        end else begin
          for (k = 0; k < held_text.len(); k++) begin
            push_char(held_text[k], k == held_text.len() - 1);
          end
        end
      end
    end
  end

  task automatic add_row(input cmd_e cmd, input logic [63:0] value, input string text);
    row_cmd.push_back(cmd);
    row_value.push_back(value);
    row_text.push_back(text);
  endtask

  // Idle for the gap, then hold start until the transfer is taken
  task automatic send_item(input cmd_e cmd, input logic [63:0] value, input string text,
                           input int unsigned gap);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    item_i    <= in_t'{cmd: cmd, value: value};
    held_text <= text;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
  endtask

  // Drop start and hold off until every owed character has come
  task automatic wait_for_drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending_chars.size() != 0);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [63:0] value;
    int unsigned gap;

    // Zero in every mode, sign extremes, widest outputs
    add_row(CMD_SDEC, 64'd0, "0");
    add_row(CMD_UDEC, 64'd0, "0");
    add_row(CMD_HEXL, 64'd0, "0x0");
    add_row(CMD_HEXU, 64'd0, "0x0");
    add_row(CMD_SDEC, 64'd1, "1");
    add_row(CMD_SDEC, AllOnes, "-1");
    add_row(CMD_SDEC, MinNeg, "-9223372036854775808");
    add_row(CMD_SDEC, MaxPos, "9223372036854775807");
    add_row(CMD_UDEC, AllOnes, "18446744073709551615");
    add_row(CMD_UDEC, MinNeg, "9223372036854775808");
    add_row(CMD_HEXL, AllOnes, "0xffffffffffffffff");
    add_row(CMD_HEXU, AllOnes, "0xFFFFFFFFFFFFFFFF");
    add_row(CMD_HEXL, MinNeg, "0x8000000000000000");
    add_row(CMD_HEXU, 64'd1, "0x1");
    // Digit boundaries and mixed patterns
    add_row(CMD_UDEC, 64'd9, "");
    add_row(CMD_UDEC, 64'd10, "");
    add_row(CMD_SDEC, 64'hffff_ffff_ffff_cfc7, "");
    add_row(CMD_UDEC, 64'd10000000000000000000, "");
    add_row(CMD_HEXL, 64'h0123_4567_89ab_cdef, "");
    add_row(CMD_HEXU, 64'hfedc_ba98_7654_3210, "");
    add_row(CMD_SDEC, 64'h5555_5555_5555_5555, "");
    add_row(CMD_UDEC, 64'haaaa_aaaa_aaaa_aaaa, "");
    add_row(CMD_HEXL, 64'h0000_0000_0000_00f0, "");
    add_row(CMD_HEXU, 64'h0000_0000_0000_0abc, "");

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (row_cmd[r]) send_item(row_cmd[r], row_value[r], row_text[r], $urandom_range(0, 4));

    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 2) wait_for_drain();
      // Spread values over full width, short lengths and both sign extremes
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: value = {$urandom, $urandom};
        5, 6:          value = {$urandom, $urandom} >> $urandom_range(0, 63);
        7:             value = 64'($urandom_range(0, 20));
        8:             value = AllOnes - 64'($urandom_range(0, 20));
        default:       value = MinNeg + 64'($urandom_range(0, 20)) - 64'd10;
      endcase
      // Every third stretch of twenty items runs back to back
      gap = ((i / 20) % 3 == 0) ? 0 : $urandom_range(0, 4);
      send_item(cmd_e'($urandom_range(0, 3)), value, "", gap);
    end

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // End a hung run
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/i2a_pkg.sv
rtl/i2a_front.sv
rtl/i2a_queue.sv
rtl/i2a_back.sv
rtl/integer_to_ascii_formatter.sv
tb/sv/integer_to_ascii_formatter_tb.sv
